>>> rtl/swc_pkg.sv
// Shared types, constants and helpers for the sphere-wall collision block.
`timescale 1ns / 1ps

package swc_pkg;

  localparam int MAX_WALLS_DEF = 8;

  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [3:0]  COUNT_RESET  = 4'd0;

  // Configuration register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // Input item kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  // -2.01 in Q16.16
  localparam logic signed [31:0] NEG_RESTIT = -32'sd131727;

  // Datapath operations; multiply ops are issued in one cycle and retired in the next
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_RR       = 4'd1,
    OP_RD       = 4'd2,
    OP_DIFF     = 4'd3,
    OP_D        = 4'd4,
    OP_SQ       = 4'd5,
    OP_R        = 4'd6,
    OP_UP       = 4'd7,
    OP_UM       = 4'd8,
    OP_FIN      = 4'd9,
    OP_DOT      = 4'd10,
    OP_K        = 4'd11,
    OP_NV       = 4'd12,
    OP_OUT_LOAD = 4'd13,
    OP_OUT_MISS = 4'd14,
    OP_OUT_HIT  = 4'd15
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic lt;
  } sts_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    sx64 = {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [1:0] comp_inc1(input logic [1:0] c);
    comp_inc1 = (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic logic [1:0] comp_inc2(input logic [1:0] c);
    comp_inc2 = (c == 2'd0) ? 2'd2 : c - 2'd1;
  endfunction

endpackage

>>> rtl/swc_ctrl.sv
// Sequencer for wall scan and collision response, plus result handshake.
`timescale 1ns / 1ps

module swc_ctrl import swc_pkg::*; #(
  parameter int MAX_WALLS = MAX_WALLS_DEF,
  parameter int IW = $clog2(MAX_WALLS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          action,
  input  logic [3:0]    wall_count,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [IW-1:0] wall_idx,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          hit,
  output logic [2:0]    wall_hit
);

  localparam int LW = (IW > 4) ? IW : 4;
  localparam logic [4:0] SCAN_LAST = 5'd6;
  localparam logic [4:0] RESP_LAST = 5'd22;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RR    = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_DIFF  = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_RESP  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  logic [4:0]    step, step_next;
  logic [IW-1:0] idx, idx_next;
  logic          is_load, is_load_next;
  logic          found, found_next;
  logic          emit_go;
  logic [LW-1:0] lim;
  logic [LW-1:0] wc;
  logic [LW-1:0] idx_inc;

  assign wc      = LW'(wall_count);
  assign lim     = (wc > LW'(MAX_WALLS)) ? LW'(MAX_WALLS) : wc;
  assign idx_inc = LW'(idx) + LW'(1);
  assign in_ready = (state == ST_IDLE);
  assign wall_idx = idx;
  assign emit_go  = (state == ST_EMIT) && (!out_valid || out_ready);

  function automatic cmd_t scan_cmd(input logic [4:0] k);
    cmd_t c;
    c = '{op: OP_NONE, comp: 2'd0};
    unique case (k)
      5'd0, 5'd1, 5'd2: c = '{op: OP_D, comp: k[1:0]};
      5'd3: c = '{op: OP_SQ, comp: 2'd0};
      5'd4: c = '{op: OP_SQ, comp: 2'd1};
      5'd5: c = '{op: OP_SQ, comp: 2'd2};
      default: c = '{op: OP_NONE, comp: 2'd0};
    endcase
    return c;
  endfunction

  function automatic cmd_t resp_cmd(input logic [4:0] k);
    cmd_t c;
    c = '{op: OP_NONE, comp: 2'd0};
    unique case (k)
      5'd0:  c = '{op: OP_R,   comp: 2'd0};
      5'd1:  c = '{op: OP_R,   comp: 2'd1};
      5'd2:  c = '{op: OP_R,   comp: 2'd2};
      5'd4:  c = '{op: OP_UP,  comp: 2'd0};
      5'd5:  c = '{op: OP_UM,  comp: 2'd0};
      5'd6:  c = '{op: OP_UP,  comp: 2'd1};
      5'd7:  c = '{op: OP_UM,  comp: 2'd1};
      5'd8:  c = '{op: OP_UP,  comp: 2'd2};
      5'd9:  c = '{op: OP_UM,  comp: 2'd2};
      5'd11: c = '{op: OP_FIN, comp: 2'd0};
      5'd12: c = '{op: OP_DOT, comp: 2'd0};
      5'd13: c = '{op: OP_DOT, comp: 2'd1};
      5'd14: c = '{op: OP_DOT, comp: 2'd2};
      5'd16: c = '{op: OP_FIN, comp: 2'd0};
      5'd17: c = '{op: OP_K,   comp: 2'd0};
      5'd19: c = '{op: OP_NV,  comp: 2'd0};
      5'd20: c = '{op: OP_NV,  comp: 2'd1};
      5'd21: c = '{op: OP_NV,  comp: 2'd2};
      default: c = '{op: OP_NONE, comp: 2'd0};
    endcase
    return c;
  endfunction

  always_comb begin
    state_next   = state;
    step_next    = step;
    idx_next     = idx;
    is_load_next = is_load;
    found_next   = found;
    cmd          = '{op: OP_NONE, comp: 2'd0};
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          idx_next   = '0;
          found_next = 1'b0;
          if (action == ACT_LOAD) begin
            is_load_next = 1'b1;
            state_next   = ST_EMIT;
          end else begin
            is_load_next = 1'b0;
            state_next   = ST_RR;
          end
        end
      end
      ST_RR: begin
        cmd        = '{op: OP_RR, comp: 2'd0};
        state_next = (lim == '0) ? ST_EMIT : ST_RD;
      end
      ST_RD: begin
        cmd        = '{op: OP_RD, comp: 2'd0};
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd        = '{op: OP_DIFF, comp: 2'd0};
        step_next  = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd       = scan_cmd(step);
        step_next = step + 5'd1;
        if (step == SCAN_LAST) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.lt) begin
          found_next = 1'b1;
          step_next  = '0;
          state_next = ST_RESP;
        end else if (idx_inc < lim) begin
          idx_next   = IW'(idx_inc);
          state_next = ST_RD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_RESP: begin
        cmd       = resp_cmd(step);
        step_next = step + 5'd1;
        if (step == RESP_LAST) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (is_load) begin
            cmd = '{op: OP_OUT_LOAD, comp: 2'd0};
          end else if (found) begin
            cmd = '{op: OP_OUT_HIT, comp: 2'd0};
          end else begin
            cmd = '{op: OP_OUT_MISS, comp: 2'd0};
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      idx       <= '0;
      is_load   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      hit       <= 1'b0;
      wall_hit  <= '0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      idx     <= idx_next;
      is_load <= is_load_next;
      found   <= found_next;
      if (emit_go) begin
        out_valid <= 1'b1;
        hit       <= found && !is_load;
        wall_hit  <= (found && !is_load) ? 3'(idx) : 3'd0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/swc_dp.sv
// Datapath: wall table, shared 32x32 multiplier and the working registers.
`timescale 1ns / 1ps

module swc_dp import swc_pkg::*; #(
  parameter int MAX_WALLS = MAX_WALLS_DEF,
  parameter int IW = $clog2(MAX_WALLS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               action,
  input  logic [2:0]         slot,
  input  logic signed [31:0] vec_a_x,
  input  logic signed [31:0] vec_a_y,
  input  logic signed [31:0] vec_a_z,
  input  logic signed [31:0] vec_b_x,
  input  logic signed [31:0] vec_b_y,
  input  logic signed [31:0] vec_b_z,
  input  logic signed [31:0] spin_x,
  input  logic signed [31:0] spin_y,
  input  logic signed [31:0] spin_z,
  input  logic [30:0]        ball_radius,
  input  cmd_t               cmd,
  input  logic [IW-1:0]      wall_idx,
  output sts_t               sts,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z
);

  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int SW = (AW > 3) ? AW + 1 : 4;

  logic [95:0] pos_mem [MAX_WALLS];
  logic [95:0] nrm_mem [MAX_WALLS];

  logic signed [31:0] a_r   [0:2];
  logic signed [31:0] b_r   [0:2];
  logic signed [31:0] s_r   [0:2];
  logic signed [31:0] pos_q [0:2];
  logic signed [31:0] nrm_q [0:2];
  logic signed [31:0] diff  [0:2];
  logic signed [31:0] d_r   [0:2];
  logic signed [31:0] rv    [0:2];
  logic signed [49:0] uacc  [0:2];
  logic signed [31:0] u_r   [0:2];
  logic signed [31:0] nv    [0:2];
  logic signed [49:0] dacc;
  logic signed [31:0] dot;
  logic signed [31:0] kf;
  logic [63:0]        sum;
  logic [63:0]        rr;
  logic signed [63:0] p;
  logic signed [63:0] f;
  cmd_t               cmd_q;
  logic signed [31:0] ma, mb;
  logic signed [31:0] rad_s;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  assign rad_s   = {1'b0, ball_radius};
  assign wr_addr = AW'(slot);
  assign rd_addr = wall_idx[AW-1:0];
  assign wr_en   = in_fire && (action == ACT_LOAD) && (SW'(slot) < SW'(MAX_WALLS));
  assign f       = p >>> 16;
  assign sts.lt  = (sum < rr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= {vec_a_z, vec_a_y, vec_a_x};
      nrm_mem[wr_addr] <= {vec_b_z, vec_b_y, vec_b_x};
    end
    if (cmd.op == OP_RD) begin
      for (int j = 0; j < 3; j++) begin
        pos_q[j] <= pos_mem[rd_addr][32*j +: 32];
        nrm_q[j] <= nrm_mem[rd_addr][32*j +: 32];
      end
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_RR:  begin ma = rad_s;                  mb = rad_s;                  end
      OP_D:   begin ma = diff[cmd.comp];         mb = nrm_q[cmd.comp];        end
      OP_SQ:  begin ma = d_r[cmd.comp];          mb = d_r[cmd.comp];          end
      OP_R:   begin ma = rad_s;                  mb = nrm_q[cmd.comp];        end
      OP_UP:  begin
        ma = rv[comp_inc1(cmd.comp)];
        mb = s_r[comp_inc2(cmd.comp)];
      end
      OP_UM:  begin
        ma = rv[comp_inc2(cmd.comp)];
        mb = s_r[comp_inc1(cmd.comp)];
      end
      OP_DOT: begin ma = u_r[cmd.comp];          mb = nrm_q[cmd.comp];        end
      OP_K:   begin ma = dot;                    mb = NEG_RESTIT;             end
      OP_NV:  begin ma = nrm_q[cmd.comp];        mb = kf;                     end
      default: begin ma = '0;                    mb = '0;                     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q <= '{op: OP_NONE, comp: 2'd0};
    end else begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;

    if (in_fire && action == ACT_TEST) begin
      a_r[0] <= vec_a_x;  a_r[1] <= vec_a_y;  a_r[2] <= vec_a_z;
      b_r[0] <= vec_b_x;  b_r[1] <= vec_b_y;  b_r[2] <= vec_b_z;
      s_r[0] <= spin_x;   s_r[1] <= spin_y;   s_r[2] <= spin_z;
    end

    // Issue-side actions
    if (cmd.op == OP_DIFF) begin
      for (int j = 0; j < 3; j++) begin
        diff[j] <= sat32(sx64(a_r[j]) - sx64(pos_q[j]));
      end
    end
    if (cmd.op == OP_D && cmd.comp == 2'd0) begin
      sum <= '0;
    end
    if (cmd.op == OP_R && cmd.comp == 2'd0) begin
      for (int j = 0; j < 3; j++) begin
        uacc[j] <= 50'(sx64(b_r[j]));
      end
    end
    if (cmd.op == OP_DOT && cmd.comp == 2'd0) begin
      dacc <= '0;
    end
    if (cmd.op == OP_FIN) begin
      for (int j = 0; j < 3; j++) begin
        u_r[j] <= sat32(64'(uacc[j]));
      end
      dot <= sat32(64'(dacc));
    end

    // Retire the product issued last cycle
    unique case (cmd_q.op)
      OP_RR:  rr <= p;
      OP_D:   d_r[cmd_q.comp] <= sat32(f);
      OP_SQ:  sum <= sum + p;
      OP_R:   rv[cmd_q.comp] <= sat32(-f);
      OP_UP:  uacc[cmd_q.comp] <= uacc[cmd_q.comp] + f[49:0];
      OP_UM:  uacc[cmd_q.comp] <= uacc[cmd_q.comp] - f[49:0];
      OP_DOT: dacc <= dacc + f[49:0];
      OP_K:   kf <= sat32(f);
      OP_NV:  nv[cmd_q.comp] <= sat32(sx64(b_r[cmd_q.comp]) + f);
      default: begin end
    endcase

    unique case (cmd.op)
      OP_OUT_LOAD: begin
        new_vel_x <= '0;
        new_vel_y <= '0;
        new_vel_z <= '0;
      end
      OP_OUT_MISS: begin
        new_vel_x <= b_r[0];
        new_vel_y <= b_r[1];
        new_vel_z <= b_r[2];
      end
      OP_OUT_HIT: begin
        new_vel_x <= nv[0];
        new_vel_y <= nv[1];
        new_vel_z <= nv[2];
      end
      default: begin end
    endcase
  end

endmodule

>>> rtl/sphere_wall_collision_response_core.sv
// Sphere-wall collision response: config registers, sequencer and datapath.
`timescale 1ns / 1ps

// A load item writes one wall slot; its all-zero result passes through the
// emit state into the output register once any earlier result is taken. A
// test item scans walls from slot zero through one 32x32 multiplier shared by
// every product: a set-up step (radius square), then for each wall scanned a
// table read, offset, three offset products, three squares and a check, and
// response maths when a wall is hit. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
// Configuration writes take effect at once.
module sphere_wall_collision_response_core import swc_pkg::*; #(
  parameter int MAX_WALLS = MAX_WALLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [2:0]         slot,
  input  logic signed [31:0] vec_a_x,
  input  logic signed [31:0] vec_a_y,
  input  logic signed [31:0] vec_a_z,
  input  logic signed [31:0] vec_b_x,
  input  logic signed [31:0] vec_b_y,
  input  logic signed [31:0] vec_b_z,
  input  logic signed [31:0] spin_x,
  input  logic signed [31:0] spin_y,
  input  logic signed [31:0] spin_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [2:0]         wall_hit,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z
);

  localparam int IW = $clog2(MAX_WALLS + 1);

  logic [30:0]   ball_radius;
  logic [3:0]    wall_count;
  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] wall_idx;
  logic          in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ball_radius <= RADIUS_RESET;
      wall_count  <= COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIUS: ball_radius <= cfg_data;
        REG_COUNT:  wall_count  <= cfg_data[3:0];
        default: begin end
      endcase
    end
  end

  swc_ctrl #(
    .MAX_WALLS(MAX_WALLS),
    .IW(IW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .wall_count(wall_count),
    .sts(sts),
    .cmd(cmd),
    .wall_idx(wall_idx),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .wall_hit(wall_hit)
  );

  swc_dp #(
    .MAX_WALLS(MAX_WALLS),
    .IW(IW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .action(action),
    .slot(slot),
    .vec_a_x(vec_a_x),
    .vec_a_y(vec_a_y),
    .vec_a_z(vec_a_z),
    .vec_b_x(vec_b_x),
    .vec_b_y(vec_b_y),
    .vec_b_z(vec_b_z),
    .spin_x(spin_x),
    .spin_y(spin_y),
    .spin_z(spin_z),
    .ball_radius(ball_radius),
    .cmd(cmd),
    .wall_idx(wall_idx),
    .sts(sts),
    .new_vel_x(new_vel_x),
    .new_vel_y(new_vel_y),
    .new_vel_z(new_vel_z)
  );

endmodule
